// ===== rtl/icwt_pkg.sv =====
// Shared types, codes and constants for the interrupt controller with timer.
package icwt_pkg;

	// Default geometry of the timer count
	localparam int COUNT_WIDTH_DEF    = 24;
	localparam int PRESCALE_SHIFT_DEF = 10;

	// Command codes
	typedef enum logic [2:0] {
		CMD_LINE   = 3'd0,
		CMD_READ   = 3'd1,
		CMD_WRITE  = 3'd2,
		CMD_ELAPSE = 3'd3,
		CMD_POLL   = 3'd4
	} cmd_t;

	// Register targets and offsets
	localparam logic       TGT_IRQ   = 1'b0;
	localparam logic       TGT_TIMER = 1'b1;
	localparam logic [1:0] OFS_MASK  = 2'd2;
	localparam logic [1:0] OFS_PEND  = 2'd3;

	// Line index with no pending bit behind it
	localparam logic [1:0] LINE_NONE = 2'd3;

	// Vector addresses
	localparam logic [15:0] VEC_NONE = 16'h0000;
	localparam logic [15:0] VEC_NMI  = 16'hFFFC;
	localparam logic [15:0] VEC_BIT0 = 16'hFFF6;
	localparam logic [15:0] VEC_BIT1 = 16'hFFF8;
	localparam logic [15:0] VEC_BIT2 = 16'hFFFA;

	// Reload byte field and count read window
	localparam int LOAD_BITS = 7;
	localparam int READ_BITS = 7;

	// Status of the shared remainder unit
	typedef struct packed {
		logic busy;
		logic done;
	} mod_stat_t;

	// NMI first, then unmasked pending bits, lowest bit first
	function automatic logic [15:0] vec_pick(input logic nmi, input logic masked,
	                                         input logic [2:0] ready);
		logic [15:0] v;
		v = VEC_NONE;
		if (nmi) begin
			v = VEC_NMI;
		end else if (!masked) begin
			if (ready[0])      v = VEC_BIT0;
			else if (ready[1]) v = VEC_BIT1;
			else if (ready[2]) v = VEC_BIT2;
		end
		return v;
	endfunction

endpackage

// ===== rtl/interrupt_controller_with_timer.sv =====
// Top level: interrupt controller with a down-counting interval timer.
//
//  channel   handshake          fields
//  -------   ----------------   --------------------------------------------------
//  command   start / busy       command target offset write_data line_index
//                               line_level cycles interrupts_masked nmi_pending
//  result    done (one cycle)   read_data interrupt_taken vector_address timer_fired
//
// An item is taken when start is high and busy is low; it passes through the
// EXEC state, and its result then strobes on done. A poll that finds timer
// underflow with a nonzero reload then also waits in the DIV state while the
// remainder unit runs (one count bit a cycle) before its result is registered.
// busy stays high until the result is registered. Reset clears all state.
// The result is held for one cycle only; the receiver cannot stall it.
module interrupt_controller_with_timer #(
	parameter int COUNT_WIDTH    = icwt_pkg::COUNT_WIDTH_DEF,
	parameter int PRESCALE_SHIFT = icwt_pkg::PRESCALE_SHIFT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  command,
	input  logic        target,
	input  logic [1:0]  offset,
	input  logic [7:0]  write_data,
	input  logic [1:0]  line_index,
	input  logic        line_level,
	input  logic [9:0]  cycles,
	input  logic        interrupts_masked,
	input  logic        nmi_pending,
	output logic        done,
	output logic [7:0]  read_data,
	output logic        interrupt_taken,
	output logic [15:0] vector_address,
	output logic        timer_fired
);

	localparam int CW  = COUNT_WIDTH;
	localparam int RLW = PRESCALE_SHIFT + icwt_pkg::LOAD_BITS + 1;
	localparam int EW  = ((CW > RLW) ? CW : RLW) + 1;
	localparam logic [CW-1:0] CNT_MAX = {1'b0, {(CW-1){1'b1}}};
	localparam logic [CW-1:0] CNT_MIN = {1'b1, {(CW-1){1'b0}}};

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_DIV
	} state_t;

	state_t state_q;

	// latched command
	logic [2:0] cmd_q;
	logic       tgt_q;
	logic [1:0] ofs_q;
	logic [7:0] wdata_q;
	logic [1:0] line_q;
	logic       level_q;
	logic [9:0] cyc_q;
	logic       masked_q;
	logic       nmi_q;

	// architectural state
	logic [2:0]     pend_q;
	logic [7:0]     mask_q;
	logic           ten_q;
	logic [RLW-1:0] reload_q;
	logic [CW-1:0]  count_q;

	// registered result
	logic        done_q;
	logic [7:0]  rd_q;
	logic        taken_q;
	logic [15:0] vec_q;
	logic        fired_q;

	logic [CW:0]     elapse_diff;
	logic [CW-1:0]   elapse_cnt;
	logic [RLW-1:0]  load_val;
	logic [CW-1:0]   load_cnt;
	logic            fire;
	logic            mod_go;
	logic [CW-1:0]   deficit;
	logic [RLW-1:0]  mod_rem;
	logic [RLW-1:0]  reload_cnt_raw;
	logic [CW-1:0]   reload_cnt;
	logic [2:0]      pend_fire;
	logic [15:0]     vec_exec;
	logic [15:0]     vec_div;
	logic [7:0]      rd_val;
	icwt_pkg::mod_stat_t mod_stat;

	// saturating subtract of elapsed cycles
	always_comb begin
		elapse_diff = {count_q[CW-1], count_q} - {{(CW-9){1'b0}}, cyc_q};
		elapse_cnt  = (elapse_diff[CW] != elapse_diff[CW-1]) ? CNT_MIN
		                                                     : elapse_diff[CW-1:0];
	end

	// reload load value, clamped to the count maximum
	always_comb begin
		load_val = RLW'({1'b0, wdata_q[icwt_pkg::LOAD_BITS-1:0]} + 8'd1) << PRESCALE_SHIFT;
		load_cnt = (EW'(load_val) > EW'(CNT_MAX)) ? CNT_MAX : CW'(load_val);
	end

	// underflow service: reload - (deficit mod reload), clamped
	always_comb begin
		fire           = ten_q && count_q[CW-1];
		deficit        = ~count_q + 1'b1;
		mod_go         = (state_q == ST_EXEC) && (cmd_q == icwt_pkg::CMD_POLL) &&
		                 fire && (reload_q != '0);
		reload_cnt_raw = reload_q - mod_rem;
		reload_cnt     = (EW'(reload_cnt_raw) > EW'(CNT_MAX)) ? CNT_MAX
		                                                      : CW'(reload_cnt_raw);
	end

	// vector selection and register reads
	always_comb begin
		pend_fire = fire ? (pend_q | 3'b100) : pend_q;
		vec_exec  = icwt_pkg::vec_pick(nmi_q, masked_q, pend_fire & ~mask_q[2:0]);
		vec_div   = icwt_pkg::vec_pick(nmi_q, masked_q, pend_q & ~mask_q[2:0]);
		rd_val    = 8'd0;
		if (tgt_q == icwt_pkg::TGT_TIMER) begin
			rd_val = {1'b0, count_q[PRESCALE_SHIFT +: icwt_pkg::READ_BITS]};
		end else if (ofs_q == icwt_pkg::OFS_MASK) begin
			rd_val = mask_q;
		end else if (ofs_q == icwt_pkg::OFS_PEND) begin
			rd_val = {5'd0, pend_q};
		end
	end

	icwt_mod #(
		.NUM_W(CW),
		.DEN_W(RLW)
	) u_mod (
		.clk   (clk),
		.arst_n(arst_n),
		.go    (mod_go),
		.num   (deficit),
		.den   (reload_q),
		.stat  (mod_stat),
		.rem   (mod_rem)
	);

	// sequencer, state registers and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cmd_q    <= '0;
			tgt_q    <= 1'b0;
			ofs_q    <= '0;
			wdata_q  <= '0;
			line_q   <= '0;
			level_q  <= 1'b0;
			cyc_q    <= '0;
			masked_q <= 1'b0;
			nmi_q    <= 1'b0;
			pend_q   <= '0;
			mask_q   <= '0;
			ten_q    <= 1'b0;
			reload_q <= '0;
			count_q  <= '0;
			done_q   <= 1'b0;
			rd_q     <= '0;
			taken_q  <= 1'b0;
			vec_q    <= '0;
			fired_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						cmd_q    <= command;
						tgt_q    <= target;
						ofs_q    <= offset;
						wdata_q  <= write_data;
						line_q   <= line_index;
						level_q  <= line_level;
						cyc_q    <= cycles;
						masked_q <= interrupts_masked;
						nmi_q    <= nmi_pending;
						state_q  <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					rd_q    <= 8'd0;
					taken_q <= 1'b0;
					vec_q   <= icwt_pkg::VEC_NONE;
					fired_q <= 1'b0;
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
					case (cmd_q)
						icwt_pkg::CMD_LINE: begin
							if (line_q != icwt_pkg::LINE_NONE) pend_q[line_q] <= level_q;
						end
						icwt_pkg::CMD_READ: begin
							rd_q <= rd_val;
						end
						icwt_pkg::CMD_WRITE: begin
							if (tgt_q == icwt_pkg::TGT_IRQ) begin
								if (ofs_q == icwt_pkg::OFS_MASK) mask_q <= wdata_q;
								else if (ofs_q == icwt_pkg::OFS_PEND) pend_q[2] <= 1'b0;
							end else if (!ofs_q[0]) begin
								reload_q <= load_val;
								count_q  <= load_cnt;
							end else begin
								ten_q <= wdata_q[0];
							end
						end
						icwt_pkg::CMD_ELAPSE: begin
							count_q <= elapse_cnt;
						end
						icwt_pkg::CMD_POLL: begin
							pend_q  <= pend_fire;
							fired_q <= fire;
							if (mod_go) begin
								done_q  <= 1'b0;
								state_q <= ST_DIV;
							end else begin
								vec_q   <= vec_exec;
								taken_q <= (vec_exec != icwt_pkg::VEC_NONE);
							end
						end
						default: begin
						end
					endcase
				end
				ST_DIV: begin
					if (mod_stat.done) begin
						count_q <= reload_cnt;
						vec_q   <= vec_div;
						taken_q <= (vec_div != icwt_pkg::VEC_NONE);
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy            = (state_q != ST_IDLE);
	assign done            = done_q;
	assign read_data       = rd_q;
	assign interrupt_taken = taken_q;
	assign vector_address  = vec_q;
	assign timer_fired     = fired_q;

	// an accepted item always makes the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("accepted item did not raise busy");

	// result strobe only while the sequencer is back at rest
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result strobe while busy");

	// taken flag agrees with the vector
	a_taken_vec: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (interrupt_taken == (vector_address != icwt_pkg::VEC_NONE)))
		else $error("taken flag and vector disagree");

	// a fired timer leaves its pending bit set
	a_fire_pend: assert property (@(posedge clk) disable iff (!arst_n)
		done && timer_fired |-> pend_q[2]) else $error("timer fired without pending bit");

	// waiting on the remainder unit implies it is working or finishing
	a_div_live: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> mod_stat.busy || mod_stat.done)
		else $error("remainder unit idle during reload");

endmodule

// ===== rtl/icwt_mod.sv =====
// Iterative restoring remainder unit: one dividend bit per cycle.
module icwt_mod #(
	parameter int NUM_W = icwt_pkg::COUNT_WIDTH_DEF,
	parameter int DEN_W = icwt_pkg::PRESCALE_SHIFT_DEF + 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              go,
	input  logic [NUM_W-1:0]  num,
	input  logic [DEN_W-1:0]  den,
	output icwt_pkg::mod_stat_t stat,
	output logic [DEN_W-1:0]  rem
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] num_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W-1:0] rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             done_q;
	logic [DEN_W:0]   trial;
	logic [DEN_W:0]   diff;

	// shift in next dividend bit, subtract divisor when it fits
	always_comb begin
		trial = {rem_q, num_q[NUM_W-1]};
		diff  = trial - {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
			num_q  <= '0;
			den_q  <= '0;
			rem_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				num_q <= num;
				den_q <= den;
				rem_q <= '0;
				cnt_q <= CNT_W'(NUM_W);
			end else if (cnt_q != '0) begin
				num_q <= num_q << 1;
				rem_q <= diff[DEN_W] ? trial[DEN_W-1:0] : diff[DEN_W-1:0];
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) done_q <= 1'b1;
			end
		end
	end

	assign stat.busy = (cnt_q != '0);
	assign stat.done = done_q;
	assign rem       = rem_q;

endmodule

// ===== tb/tb_interrupt_controller_with_timer.sv =====
// Self-checking testbench for the interrupt controller with interval timer.
`timescale 1ns / 1ps

module tb_interrupt_controller_with_timer;
	import icwt_pkg::*;

	localparam int CW = COUNT_WIDTH_DEF;
	localparam int PS = PRESCALE_SHIFT_DEF;
	localparam longint COUNT_MAX = (longint'(1) << (CW - 1)) - 1;
	localparam longint COUNT_MIN = -(longint'(1) << (CW - 1));

	// Codes the package leaves unnamed
	localparam logic [2:0] CMD_SPARE_LO = 3'd5;
	localparam logic [2:0] CMD_SPARE_HI = 3'd7;
	localparam logic [1:0] OFS_SPARE    = 2'd0;
	localparam logic [1:0] OFS_RELOAD   = 2'd0;
	localparam logic [1:0] OFS_ENABLE   = 2'd1;
	localparam logic [9:0] CYC_MAX      = '1;
	localparam logic [26:0] UNTYPED     = '0;

	// Run sizing
	localparam int RANDOM_ITEMS  = 1700;
	localparam int DRAIN_CYCLES  = CW + 8;
	localparam int IDLE_LIMIT    = 1000;
	localparam int REPORT_LIMIT  = 40;

	// One command item, with an optional hand-typed result
	typedef struct packed {
		logic [2:0]  cmd;
		logic        tgt;
		logic [1:0]  ofs;
		logic [7:0]  data;
		logic [1:0]  line;
		logic        lvl;
		logic [9:0]  cyc;
		logic        msk;
		logic        nmi;
		logic        typed;
		logic [7:0]  rd;
		logic        taken;
		logic [15:0] vec;
		logic        fired;
	} stim_row_t;

	typedef struct packed {
		logic [7:0]  rd;
		logic        taken;
		logic [15:0] vec;
		logic        fired;
	} ctl_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [2:0]  command = '0;
	logic        target = 1'b0;
	logic [1:0]  offset = '0;
	logic [7:0]  write_data = '0;
	logic [1:0]  line_index = '0;
	logic        line_level = 1'b0;
	logic [9:0]  cycles = '0;
	logic        interrupts_masked = 1'b0;
	logic        nmi_pending = 1'b0;
	logic        done;
	logic [7:0]  read_data;
	logic        interrupt_taken;
	logic [15:0] vector_address;
	logic        timer_fired;

	// Hand-typed result travelling with the item on the ports
	logic        typed_flag = 1'b0;
	ctl_result_t typed_res = '0;

	// Predicted controller state
	logic [2:0] pend_m;
	logic [7:0] mask_m;
	logic       en_m;
	longint     reload_m;
	longint     count_m;

	ctl_result_t awaited_results[$];
	int mismatches = 0;
	int items_accepted = 0;
	int polls = 0;
	int fired_polls = 0;
	int vectors_taken = 0;
	int idle_cycles = 0;
	int burst_left = 0;

	interrupt_controller_with_timer #(
		.COUNT_WIDTH(CW),
		.PRESCALE_SHIFT(PS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.command(command),
		.target(target),
		.offset(offset),
		.write_data(write_data),
		.line_index(line_index),
		.line_level(line_level),
		.cycles(cycles),
		.interrupts_masked(interrupts_masked),
		.nmi_pending(nmi_pending),
		.done(done),
		.read_data(read_data),
		.interrupt_taken(interrupt_taken),
		.vector_address(vector_address),
		.timer_fired(timer_fired)
	);

	always #5 clk = ~clk;

	function automatic longint sat_count(input longint v);
		if (v > COUNT_MAX) return COUNT_MAX;
		if (v < COUNT_MIN) return COUNT_MIN;
		return v;
	endfunction

	// Apply one command to the predicted state and return its result
	function automatic ctl_result_t step_controller(input stim_row_t s);
		ctl_result_t r;
		logic [2:0] ready;
		logic [CW-1:0] bits;
		longint deficit;
		r = '0;
		case (s.cmd)
		CMD_LINE: begin
			if (s.line != LINE_NONE) pend_m[s.line] = s.lvl;
		end
		CMD_READ: begin
			if (s.tgt == TGT_IRQ) begin
				if (s.ofs == OFS_MASK) r.rd = mask_m;
				else if (s.ofs == OFS_PEND) r.rd = {5'b0, pend_m};
			end else begin
				// count window above the prescaler, two's complement
				bits = count_m[CW-1:0];
				r.rd = {1'b0, bits[PS +: READ_BITS]};
			end
		end
		CMD_WRITE: begin
			if (s.tgt == TGT_IRQ) begin
				if (s.ofs == OFS_MASK) mask_m = s.data;
				else if (s.ofs == OFS_PEND) pend_m[2] = 1'b0;
			end else if (!s.ofs[0]) begin
				reload_m = (longint'(s.data[LOAD_BITS-1:0]) + 1) << PS;
				count_m = sat_count(reload_m);
			end else begin
				en_m = s.data[0];
			end
		end
		CMD_ELAPSE: begin
			count_m = sat_count(count_m - longint'(s.cyc));
		end
		CMD_POLL: begin
			// underflow: flag the timer, reload by the remainder of the deficit
			if (en_m && count_m < 0) begin
				r.fired = 1'b1;
				pend_m[2] = 1'b1;
				if (reload_m > 0) begin
					deficit = -count_m;
					count_m = sat_count(reload_m - deficit % reload_m);
				end
			end
			ready = pend_m & ~mask_m[2:0];
			if (s.nmi) r.vec = VEC_NMI;
			else if (!s.msk) begin
				if (ready[0]) r.vec = VEC_BIT0;
				else if (ready[1]) r.vec = VEC_BIT1;
				else if (ready[2]) r.vec = VEC_BIT2;
			end
			r.taken = (r.vec != VEC_NONE);
		end
		default: ;
		endcase
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [15:0] got,
	                               input logic [15:0] want);
		mismatches++;
		if (mismatches <= REPORT_LIMIT)
			$display("%0t: %s: got %0h, expected %0h", $time, what, got, want);
	endtask

	// Present one item, hold it until taken, then maybe leave a gap
	task automatic issue(input stim_row_t s, input bit paced);
		int gap;
		@(negedge clk);
		start <= 1'b1;
		command <= s.cmd;
		target <= s.tgt;
		offset <= s.ofs;
		write_data <= s.data;
		line_index <= s.line;
		line_level <= s.lvl;
		cycles <= s.cyc;
		interrupts_masked <= s.msk;
		nmi_pending <= s.nmi;
		typed_flag <= s.typed;
		typed_res <= {s.rd, s.taken, s.vec, s.fired};
		@(posedge clk);
		while (busy !== 1'b0) @(posedge clk);
		if (paced) begin
			if (burst_left > 0) begin
				burst_left--;
			end else begin
				// idle with junk on the fields, then pick the next burst
				gap = $urandom_range(1, 8);
				@(negedge clk);
				start <= 1'b0;
				{command, target, offset, write_data, line_index, line_level,
				 cycles, interrupts_masked, nmi_pending} <= 29'($urandom);
				repeat (gap - 1) @(negedge clk);
				burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
				                                        : $urandom_range(0, 6);
			end
		end
	endtask

	// Result checking, prediction at acceptance, idle watchdog
	always @(posedge clk) begin : monitor
		ctl_result_t got;
		ctl_result_t want;
		stim_row_t seen;
		logic moved;
		moved = 1'b0;
		if (arst_n) begin
			if (done === 1'b1) begin
				moved = 1'b1;
				got = {read_data, interrupt_taken, vector_address, timer_fired};
				if (awaited_results.size() == 0) begin
					report_mismatch("result with no item outstanding", got.vec, VEC_NONE);
				end else begin
					want = awaited_results.pop_front();
					if (got.rd !== want.rd)
						report_mismatch("read_data", 16'(got.rd), 16'(want.rd));
					if (got.taken !== want.taken)
						report_mismatch("interrupt_taken", 16'(got.taken), 16'(want.taken));
					if (got.vec !== want.vec)
						report_mismatch("vector_address", got.vec, want.vec);
					if (got.fired !== want.fired)
						report_mismatch("timer_fired", 16'(got.fired), 16'(want.fired));
				end
			end
			if (start && busy === 1'b0) begin
				moved = 1'b1;
				seen = {command, target, offset, write_data, line_index, line_level,
				        cycles, interrupts_masked, nmi_pending, typed_flag, typed_res};
				want = step_controller(seen);
				items_accepted++;
				if (seen.cmd == CMD_POLL) polls++;
				if (want.fired) fired_polls++;
				if (want.taken) vectors_taken++;
				if (typed_flag) want = typed_res;
				awaited_results.push_back(want);
			end
		end
		if (moved) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Timeout: no handshake for %0d cycles", IDLE_LIMIT);
				$display("Mismatches found");
				$finish;
			end
		end
	end

	initial begin : stimulus
		stim_row_t dir_rows[$];
		stim_row_t row;
		int pick;
		pend_m = '0;
		mask_m = '0;
		en_m = 1'b0;
		reload_m = 0;
		count_m = 0;

		// Directed table: cmd tgt ofs data line lvl cyc msk nmi | typed rd taken vec fired
		// reset values, then zero-reload underflow, NMI over the I flag
		dir_rows.push_back({CMD_READ, TGT_IRQ, OFS_MASK, 8'h00, 2'd0, 1'b0, 10'd0, 1'b0,
		                    1'b0, 1'b1, 8'h00, 1'b0, VEC_NONE, 1'b0});
		dir_rows.push_back({CMD_READ, TGT_IRQ, OFS_PEND, 8'h00, 2'd0, 1'b0, 10'd0, 1'b0,
		                    1'b0, 1'b1, 8'h00, 1'b0, VEC_NONE, 1'b0});
		dir_rows.push_back({CMD_READ, TGT_TIMER, OFS_RELOAD, 8'h00, 2'd0, 1'b0, 10'd0,
		                    1'b0, 1'b0, 1'b1, 8'h00, 1'b0, VEC_NONE, 1'b0});
		dir_rows.push_back({CMD_POLL, TGT_IRQ, OFS_SPARE, 8'h00, 2'd0, 1'b0, 10'd0, 1'b0,
		                    1'b0, 1'b1, 8'h00, 1'b0, VEC_NONE, 1'b0});
		dir_rows.push_back({CMD_WRITE, TGT_TIMER, OFS_ENABLE, 8'h01, 2'd0, 1'b0, 10'd0,
		                    1'b0, 1'b0, 1'b1, 8'h00, 1'b0, VEC_NONE, 1'b0});
		dir_rows.push_back({CMD_ELAPSE, TGT_IRQ, OFS_SPARE, 8'h00, 2'd0, 1'b0, CYC_MAX,
		                    1'b0, 1'b0, UNTYPED});
		dir_rows.push_back({CMD_POLL, TGT_IRQ, OFS_SPARE, 8'h00, 2'd0, 1'b0, 10'd0, 1'b0,
		                    1'b0, 1'b1, 8'h00, 1'b1, VEC_BIT2, 1'b1});
		dir_rows.push_back({CMD_READ, TGT_TIMER, OFS_ENABLE, 8'h00, 2'd0, 1'b0, 10'd0,
		                    1'b0, 1'b0, UNTYPED});
		dir_rows.push_back({CMD_POLL, TGT_IRQ, OFS_SPARE, 8'h00, 2'd0, 1'b0, 10'd0, 1'b1,
		                    1'b1, 1'b1, 8'h00, 1'b1, VEC_NMI, 1'b1});
		// full mask blocks everything, line changes, ignored line
		dir_rows.push_back({CMD_WRITE, TGT_IRQ, OFS_MASK, 8'hFF, 2'd0, 1'b0, 10'd0, 1'b0,
		                    1'b0, 1'b1, 8'h00, 1'b0, VEC_NONE, 1'b0});
		dir_rows.push_back({CMD_READ, TGT_IRQ, OFS_MASK, 8'h00, 2'd0, 1'b0, 10'd0, 1'b0,
		                    1'b0, 1'b1, 8'hFF, 1'b0, VEC_NONE, 1'b0});
		dir_rows.push_back({CMD_LINE, TGT_IRQ, OFS_SPARE, 8'h00, 2'd0, 1'b1, 10'd0, 1'b0,
		                    1'b0, UNTYPED});
		dir_rows.push_back({CMD_LINE, TGT_IRQ, OFS_SPARE, 8'h00, 2'd1, 1'b1, 10'd0, 1'b0,
		                    1'b0, UNTYPED});
		dir_rows.push_back({CMD_LINE, TGT_IRQ, OFS_SPARE, 8'h00, LINE_NONE, 1'b1, 10'd0,
		                    1'b0, 1'b0, UNTYPED});
		dir_rows.push_back({CMD_READ, TGT_IRQ, OFS_PEND, 8'h00, 2'd0, 1'b0, 10'd0, 1'b0,
		                    1'b0, UNTYPED});
		dir_rows.push_back({CMD_POLL, TGT_IRQ, OFS_SPARE, 8'h00, 2'd0, 1'b0, 10'd0, 1'b0,
		                    1'b0, UNTYPED});
		dir_rows.push_back({CMD_WRITE, TGT_IRQ, OFS_MASK, 8'h00, 2'd0, 1'b0, 10'd0, 1'b0,
		                    1'b0, UNTYPED});
		dir_rows.push_back({CMD_POLL, TGT_IRQ, OFS_SPARE, 8'h00, 2'd0, 1'b0, 10'd0, 1'b1,
		                    1'b0, UNTYPED});
		// clear timer pending, drop line 0, load the shortest reload and underflow it
		dir_rows.push_back({CMD_WRITE, TGT_IRQ, OFS_PEND, 8'hAA, 2'd0, 1'b0, 10'd0, 1'b0,
		                    1'b0, UNTYPED});
		dir_rows.push_back({CMD_LINE, TGT_IRQ, OFS_SPARE, 8'h00, 2'd0, 1'b0, 10'd0, 1'b0,
		                    1'b0, UNTYPED});
		dir_rows.push_back({CMD_WRITE, TGT_TIMER, OFS_RELOAD, 8'h80, 2'd0, 1'b0, 10'd0,
		                    1'b0, 1'b0, UNTYPED});
		dir_rows.push_back({CMD_ELAPSE, TGT_IRQ, OFS_SPARE, 8'h00, 2'd0, 1'b0, CYC_MAX,
		                    1'b0, 1'b0, UNTYPED});
		dir_rows.push_back({CMD_ELAPSE, TGT_IRQ, OFS_SPARE, 8'h00, 2'd0, 1'b0, CYC_MAX,
		                    1'b0, 1'b0, UNTYPED});
		dir_rows.push_back({CMD_POLL, TGT_IRQ, OFS_SPARE, 8'h00, 2'd0, 1'b0, 10'd0, 1'b0,
		                    1'b0, UNTYPED});
		// unused offset write, unknown command
		dir_rows.push_back({CMD_WRITE, TGT_IRQ, OFS_SPARE, 8'h55, 2'd0, 1'b0, 10'd0, 1'b0,
		                    1'b0, UNTYPED});
		dir_rows.push_back({CMD_SPARE_HI, TGT_TIMER, OFS_ENABLE, 8'hFF, LINE_NONE, 1'b1,
		                    CYC_MAX, 1'b1, 1'b1, 1'b1, 8'h00, 1'b0, VEC_NONE, 1'b0});

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i]) issue(dir_rows[i], 1'b1);

		// Random commands; timer loads kept short so underflow is frequent
		repeat (RANDOM_ITEMS) begin
			row = '0;
			row.tgt = 1'($urandom);
			row.ofs = 2'($urandom);
			row.data = 8'($urandom);
			row.line = 2'($urandom);
			row.lvl = 1'($urandom);
			row.cyc = 10'($urandom);
			row.msk = ($urandom_range(0, 3) == 0);
			row.nmi = ($urandom_range(0, 9) == 0);
			pick = $urandom_range(0, 99);
			if (pick < 18) begin
				row.cmd = CMD_LINE;
			end else if (pick < 36) begin
				row.cmd = CMD_READ;
			end else if (pick < 56) begin
				row.cmd = CMD_WRITE;
				if (row.tgt == TGT_TIMER && !row.ofs[0] && $urandom_range(0, 3) != 0)
					row.data[LOAD_BITS-1:0] = LOAD_BITS'($urandom_range(0, 3));
				if (row.tgt == TGT_TIMER && row.ofs[0] && $urandom_range(0, 4) != 0)
					row.data[0] = 1'b1;
			end else if (pick < 78) begin
				row.cmd = CMD_ELAPSE;
				if ($urandom_range(0, 1) != 0) row.cyc[9:8] = 2'b11;
			end else if (pick < 97) begin
				row.cmd = CMD_POLL;
			end else begin
				row.cmd = 3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
			end
			issue(row, 1'b1);
		end

		@(negedge clk);
		start <= 1'b0;
		while (awaited_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d items: %0d polls, %0d timer underflows, %0d vectors taken.",
		         items_accepted, polls, fired_polls, vectors_taken);
		$display("Directed table first, then random commands sent in bursts with gaps.");
		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
